/* rtl/cfe_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package cfe_pkg;

  localparam int BYTE_BITS    = 8;
  localparam int SPAN_BITS    = BYTE_BITS + 1;
  localparam int OFF_BITS     = $clog2(BYTE_BITS);
  localparam int RES_BITS     = 2 * BYTE_BITS;
  localparam int PROD_BITS    = BYTE_BITS + SPAN_BITS;
  localparam int DIV_STAGES   = BYTE_BITS;
  localparam int QUEUE_DEPTH  = 2;
  localparam int CFG_IDX_BITS = 2;

  localparam logic                 MASK_MODE_RST = 1'b0;
  localparam logic [BYTE_BITS-1:0] BIT_MASK_RST  = 8'd255;
  localparam logic [BYTE_BITS-1:0] RADIX_RST     = 8'd1;
  localparam logic [BYTE_BITS-1:0] MAX_VALUE_RST = 8'd255;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_SET = 1'b1;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_MASK_MODE = 2'd0,
    CFG_BIT_MASK  = 2'd1,
    CFG_RADIX     = 2'd2,
    CFG_MAX_VALUE = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    KIND_MASK_GET  = 3'd0,
    KIND_MASK_SET  = 3'd1,
    KIND_RADIX_GET = 3'd2,
    KIND_RADIX_SET = 3'd3,
    KIND_RADIX_ERR = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t                kind;
    logic [BYTE_BITS-1:0] cv;
    logic [BYTE_BITS-1:0] nv;
    logic [BYTE_BITS-1:0] mask;
    logic [OFF_BITS-1:0]  off;
    logic [BYTE_BITS-1:0] radix;
    logic [SPAN_BITS-1:0] span;
    logic [SPAN_BITS-1:0] blk;
  } job_t;

  // One restoring divider: partial remainder and the dividend/quotient shift word.
  typedef struct packed {
    logic [SPAN_BITS-1:0] rem;
    logic [BYTE_BITS-1:0] quo;
  } div_lane_t;

  typedef struct packed {
    div_lane_t cv_radix;
    div_lane_t nv_span;
    div_lane_t cv_blk;
  } div_set_t;

  function automatic div_lane_t div_step(input div_lane_t x, input logic [SPAN_BITS-1:0] d);
    div_lane_t        y;
    logic [SPAN_BITS:0] trial;
    trial = {x.rem, x.quo[BYTE_BITS-1]};
    if (trial >= {1'b0, d}) begin
      y.rem = SPAN_BITS'(trial - {1'b0, d});
      y.quo = {x.quo[BYTE_BITS-2:0], 1'b1};
    end else begin
      y.rem = trial[SPAN_BITS-1:0];
      y.quo = {x.quo[BYTE_BITS-2:0], 1'b0};
    end
    return y;
  endfunction

endpackage
`default_nettype wire

/* rtl/cfe_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface cfe_in_if;
  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic [cfe_pkg::BYTE_BITS-1:0] cv_value;
  logic [cfe_pkg::BYTE_BITS-1:0] new_value;

  modport source (output valid, output operation, output cv_value, output new_value,
                  input ready);
  modport sink (input valid, input operation, input cv_value, input new_value,
                output ready);
endinterface
`default_nettype wire

/* rtl/cfe_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface cfe_out_if;
  logic                         valid;
  logic                         ready;
  logic [cfe_pkg::RES_BITS-1:0] result_value;
  logic                         radix_error;

  modport source (output valid, output result_value, output radix_error, input ready);
  modport sink (input valid, input result_value, input radix_error, output ready);
endinterface
`default_nettype wire

/* rtl/cv_field_extract_insert.sv */
`timescale 1ns / 1ps
`default_nettype none
// Configuration-byte field get/set engine.
// in_chan carries one transaction per request: operation (get or set), the current
// byte cv_value and, for set, new_value. out_chan returns one transaction per request,
// in order: result_value (extracted field, or rebuilt byte) and radix_error.
// cfg_we/cfg_index/cfg_wdata write mask_mode, bit_mask, radix and max_value; write
// them only while no request is in flight.
// From input acceptance a request passes one front register, one queue slot, eight
// divider stages (one quotient bit each, three dividers side by side), one multiply
// stage and the output register.
// Throughput is one transaction per cycle while out_chan does not stall; the bit-serial
// divider pipeline sets the latency, not the rate.
// Reset loads the register defaults (bit-mask mode, mask 255, radix 1, max 255) and
// empties every stage and the queue.
// When out_chan stalls, the back pipe holds as a whole; the two-entry queue and the
// front register keep accepting until they fill, then in_chan.ready drops.
module cv_field_extract_insert (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  cfe_in_if.sink                                in_chan,
  cfe_out_if.source                             out_chan,
  input  wire logic                             cfg_we,
  input  wire logic [cfe_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [cfe_pkg::BYTE_BITS-1:0]    cfg_wdata
);
  import cfe_pkg::*;

  logic push_valid, push_ready;
  job_t push_data;
  logic pop_valid, pop_ready;
  job_t pop_data;

  cfe_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_chan    (in_chan),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  cfe_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  cfe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_chan  (out_chan)
  );

endmodule
`default_nettype wire

/* rtl/cfe_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module cfe_front (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [cfe_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [cfe_pkg::BYTE_BITS-1:0]    cfg_wdata,
  cfe_in_if.sink                                in_chan,
  output logic                                  push_valid,
  input  wire logic                             push_ready,
  output cfe_pkg::job_t                         push_data
);
  import cfe_pkg::*;

  logic                 mask_mode_r, mask_mode_nxt;
  logic [BYTE_BITS-1:0] bit_mask_r, bit_mask_nxt;
  logic [BYTE_BITS-1:0] radix_r, radix_nxt;
  logic [BYTE_BITS-1:0] max_value_r, max_value_nxt;

  logic                 f_v_r, f_v_nxt;
  job_t                 f_job_r, f_job_nxt;

  logic                 in_take;
  logic [OFF_BITS-1:0]  off;
  logic [SPAN_BITS-1:0] span;
  logic [PROD_BITS-1:0] blk_full;

  always_comb begin
    mask_mode_nxt = mask_mode_r;
    bit_mask_nxt  = bit_mask_r;
    radix_nxt     = radix_r;
    max_value_nxt = max_value_r;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_MASK_MODE: mask_mode_nxt = cfg_wdata[0];
        CFG_BIT_MASK:  bit_mask_nxt  = cfg_wdata;
        CFG_RADIX:     radix_nxt     = cfg_wdata;
        CFG_MAX_VALUE: max_value_nxt = cfg_wdata;
      endcase
    end
  end

  // Position of the lowest set mask bit; an empty mask gives zero.
  always_comb begin
    off = '0;
    for (int i = BYTE_BITS - 1; i >= 0; i--) begin
      if (bit_mask_r[i]) begin
        off = OFF_BITS'(i);
      end
    end
  end

  assign span     = {1'b0, max_value_r} + SPAN_BITS'(1);
  assign blk_full = PROD_BITS'(radix_r) * PROD_BITS'(span);

  assign in_chan.ready = !f_v_r || push_ready;
  assign in_take       = in_chan.valid && in_chan.ready;

  always_comb begin
    f_job_nxt       = f_job_r;
    f_v_nxt         = f_v_r;
    if (in_take) begin
      f_v_nxt         = 1'b1;
      f_job_nxt.cv    = in_chan.cv_value;
      f_job_nxt.nv    = in_chan.new_value;
      f_job_nxt.mask  = bit_mask_r;
      f_job_nxt.off   = off;
      f_job_nxt.radix = radix_r;
      f_job_nxt.span  = span;
      // A block wider than a byte leaves no high part; 2^BYTE_BITS stands in for it.
      if (blk_full > PROD_BITS'((1 << BYTE_BITS) - 1)) begin
        f_job_nxt.blk = SPAN_BITS'(1 << BYTE_BITS);
      end else begin
        f_job_nxt.blk = blk_full[SPAN_BITS-1:0];
      end
      priority if (!mask_mode_r) begin
        f_job_nxt.kind = (in_chan.operation == OP_SET) ? KIND_MASK_SET : KIND_MASK_GET;
      end else if (radix_r == '0) begin
        f_job_nxt.kind = KIND_RADIX_ERR;
      end else begin
        f_job_nxt.kind = (in_chan.operation == OP_SET) ? KIND_RADIX_SET : KIND_RADIX_GET;
      end
    end else if (push_ready) begin
      f_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_mode_r <= MASK_MODE_RST;
      bit_mask_r  <= BIT_MASK_RST;
      radix_r     <= RADIX_RST;
      max_value_r <= MAX_VALUE_RST;
      f_v_r       <= 1'b0;
    end else begin
      mask_mode_r <= mask_mode_nxt;
      bit_mask_r  <= bit_mask_nxt;
      radix_r     <= radix_nxt;
      max_value_r <= max_value_nxt;
      f_v_r       <= f_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    f_job_r <= f_job_nxt;
  end

  assign push_valid = f_v_r;
  assign push_data  = f_job_r;

endmodule
`default_nettype wire

/* rtl/cfe_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
module cfe_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push_valid,
  output logic               push_ready,
  input  wire cfe_pkg::job_t push_data,
  output logic               pop_valid,
  input  wire logic          pop_ready,
  output cfe_pkg::job_t      pop_data
);
  import cfe_pkg::*;

  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  job_t                mem_r [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_BITS-1:0] count_r, count_nxt;
  logic                push, pop;

  assign push_ready = count_r != CNT_BITS'(QUEUE_DEPTH);
  assign pop_valid  = count_r != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_BITS'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_BITS'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_BITS'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

/* rtl/cfe_back.sv */
`timescale 1ns / 1ps
`default_nettype none
module cfe_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          pop_valid,
  output logic               pop_ready,
  input  wire cfe_pkg::job_t pop_data,
  cfe_out_if.source          out_chan
);
  import cfe_pkg::*;

  function automatic div_set_t step_set(input div_set_t x, input job_t j);
    div_set_t y;
    y.cv_radix = div_step(x.cv_radix, {1'b0, j.radix});
    y.nv_span  = div_step(x.nv_span, j.span);
    y.cv_blk   = div_step(x.cv_blk, j.blk);
    return y;
  endfunction

  logic     en;

  logic     s_v_r   [DIV_STAGES];
  job_t     s_job_r [DIV_STAGES];
  div_set_t s_div_r [DIV_STAGES];
  div_set_t s_div_nxt [DIV_STAGES];
  div_set_t init_set;

  job_t                 lj;
  div_set_t             ld;
  logic [BYTE_BITS-1:0] mul_a;
  logic [SPAN_BITS-1:0] mul_b;

  logic                 m_v_r;
  job_t                 m_job_r;
  logic [PROD_BITS-1:0] m_prod_r, m_prod_nxt;
  logic [BYTE_BITS-1:0] m_q1_r;
  logic [BYTE_BITS-1:0] m_low_r;
  logic [BYTE_BITS-1:0] m_high_r, m_high_nxt;

  logic                 out_v_r;
  logic [RES_BITS-1:0]  out_res_r, out_res_nxt;
  logic                 out_err_r, out_err_nxt;
  logic [BYTE_BITS-1:0] nv_sh;

  // The whole back pipe moves together; it halts only while a result waits.
  assign en        = !out_v_r || out_chan.ready;
  assign pop_ready = en;

  always_comb begin
    init_set.cv_radix = '{rem: '0, quo: pop_data.cv};
    init_set.nv_span  = '{rem: '0, quo: pop_data.nv};
    init_set.cv_blk   = '{rem: '0, quo: pop_data.cv};
    s_div_nxt[0] = step_set(init_set, pop_data);
    for (int k = 1; k < DIV_STAGES; k++) begin
      s_div_nxt[k] = step_set(s_div_r[k-1], s_job_r[k-1]);
    end
  end

  // Quotients and remainders after the last divider stage.
  assign lj = s_job_r[DIV_STAGES-1];
  assign ld = s_div_r[DIV_STAGES-1];

  always_comb begin
    if (lj.kind == KIND_RADIX_GET) begin
      mul_a = ld.cv_blk.quo;
      mul_b = lj.span;
    end else begin
      mul_a = ld.nv_span.rem[BYTE_BITS-1:0];
      mul_b = {1'b0, lj.radix};
    end
    m_prod_nxt = PROD_BITS'(mul_a) * PROD_BITS'(mul_b);
    m_high_nxt = lj.cv - ld.cv_blk.rem[BYTE_BITS-1:0];
  end

  always_comb begin
    nv_sh       = m_job_r.nv << m_job_r.off;
    out_res_nxt = '0;
    out_err_nxt = 1'b0;
    unique case (m_job_r.kind)
      KIND_MASK_GET:  out_res_nxt = RES_BITS'((m_job_r.cv & m_job_r.mask) >> m_job_r.off);
      KIND_MASK_SET:  out_res_nxt = RES_BITS'((m_job_r.cv & ~m_job_r.mask) |
                                              (nv_sh & m_job_r.mask));
      KIND_RADIX_GET: out_res_nxt = RES_BITS'(m_q1_r - m_prod_r[BYTE_BITS-1:0]);
      KIND_RADIX_SET: out_res_nxt = RES_BITS'(m_high_r) + m_prod_r[RES_BITS-1:0] +
                                    RES_BITS'(m_low_r);
      KIND_RADIX_ERR: out_err_nxt = 1'b1;
      default: begin
        out_res_nxt = '0;
        out_err_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        s_v_r[k] <= 1'b0;
      end
      m_v_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else if (en) begin
      s_v_r[0] <= pop_valid;
      for (int k = 1; k < DIV_STAGES; k++) begin
        s_v_r[k] <= s_v_r[k-1];
      end
      m_v_r   <= s_v_r[DIV_STAGES-1];
      out_v_r <= m_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_job_r[0] <= pop_data;
      for (int k = 1; k < DIV_STAGES; k++) begin
        s_job_r[k] <= s_job_r[k-1];
      end
      for (int k = 0; k < DIV_STAGES; k++) begin
        s_div_r[k] <= s_div_nxt[k];
      end
      m_job_r   <= lj;
      m_prod_r  <= m_prod_nxt;
      m_q1_r    <= ld.cv_radix.quo;
      m_low_r   <= ld.cv_radix.rem[BYTE_BITS-1:0];
      m_high_r  <= m_high_nxt;
      out_res_r <= out_res_nxt;
      out_err_r <= out_err_nxt;
    end
  end

  assign out_chan.valid        = out_v_r;
  assign out_chan.result_value = out_res_r;
  assign out_chan.radix_error  = out_err_r;

endmodule
`default_nettype wire
